@@ rtl/pqadc_pkg.sv @@
// ----------------------------------------------------------------------------
// pqadc_pkg
// Shared types, constants and codes of the PQ ADC range filter.
// ----------------------------------------------------------------------------
package pqadc_pkg;

  localparam int unsigned SUBQ_DEFAULT = 16;
  localparam int unsigned CENTROIDS    = 256;
  localparam int unsigned CODE_BITS    = 8;
  localparam int unsigned GROUP_SIZE   = 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TIDX_W   = 12;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CODES_W  = GROUP_SIZE * CODE_BITS;
  localparam int unsigned ID_W     = 63;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned DIST_W   = 40;
  localparam int unsigned CONF_W   = 17;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  // group sum of eight 32-bit terms
  localparam int unsigned GSUM_W   = VAL_W + 3;
  // err * conf >> 16
  localparam int unsigned PROD_W   = ERR_W + CONF_W;
  localparam int unsigned PEN_W    = PROD_W - 16;
  // root of (distance << 16), distance below 2^39
  localparam int unsigned RAD_W    = DIST_W + 16;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 3;

  localparam logic [CONF_W-1:0] CONF_MAX = CONF_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_CODE  = 2'd1,
    OP_BEGIN = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_METRIC = 3'd0,
    REG_CONF   = 3'd1,
    REG_BASE   = 3'd2,
    REG_RADIUS = 3'd3,
    REG_RROOT  = 3'd4,
    REG_KEY    = 3'd5,
    REG_PAIRS  = 3'd6,
    REG_SPARE  = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_ACC,
    ST_SQRT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic                     metric_ip;
    logic [CONF_W-1:0]        confidence;
    logic signed [VAL_W-1:0]  base_distance;
    logic signed [VAL_W-1:0]  radius;
    logic [VAL_W-1:0]         radius_root;
    logic [KEY_W-1:0]         list_key;
    logic                     pairs_en;
  } cfg_t;

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic sqrt_start;
    logic out_load;
  } ctrl_t;

endpackage

@@ rtl/pqadc_if.sv @@
// ----------------------------------------------------------------------------
// pqadc_in_if / pqadc_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface pqadc_in_if import pqadc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [TIDX_W-1:0]         table_index;
  logic signed [VAL_W-1:0]   table_value;
  logic [CODES_W-1:0]        subcodes;
  logic [ID_W-1:0]           entry_id;
  logic [ERR_W-1:0]          recon_error;

  modport source (output valid, operation, table_index, table_value, subcodes,
                  entry_id, recon_error, input ready);
  modport sink (input valid, operation, table_index, table_value, subcodes,
                entry_id, recon_error, output ready);
endinterface

interface pqadc_out_if import pqadc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [DIST_W-1:0]  distance;
  logic [ID_W-1:0]           result_id;

  modport source (output valid, hit, distance, result_id, input ready);
  modport sink (input valid, hit, distance, result_id, output ready);
endinterface

@@ rtl/pq_adc_range_filter_unit.sv @@
// ----------------------------------------------------------------------------
// pq_adc_range_filter_unit
// Product-quantization distance scan with range decision per vector.
// ----------------------------------------------------------------------------
// in_if carries one word per handshake: a table load, a code group of eight
// subcodes, or a begin-list marker. SUBQUANTIZERS/8 code groups make one
// vector; its last group yields one word on out_if (hit, distance, id).
// The table sits in eight banked RAMs, one per subcode lane, so a group
// is read from all lanes at once. A word is taken only in the idle state:
//   load, begin list, unused code : no further states
//   code group, not last          : read, add lanes, accumulate
//   last group, plain mode        : read, add lanes, accumulate, finish
//   last group, confidence mode   : as plain, with the bit-serial square root
//                                   (one root bit per cycle) for a sum >= 0
// The result sits in an output register; the next word is accepted while
// it waits. Only a new result blocks on a full register (receiver stall).
// Reset clears the configuration, running sum, counters and output valid;
// table contents are undefined until loaded. Configuration goes through APB;
// the user must write it only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module pq_adc_range_filter_unit import pqadc_pkg::*; #(
  parameter int unsigned SUBQUANTIZERS = SUBQ_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pqadc_in_if.sink           in_if,
  pqadc_out_if.source        out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned GROUPS     = SUBQUANTIZERS / GROUP_SIZE;
  localparam int unsigned BANK_DEPTH = GROUPS * CENTROIDS;
  localparam int unsigned AW         = $clog2(BANK_DEPTH);
  localparam int unsigned GCW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned MW         = TIDX_W - CODE_BITS;

  cfg_t   cfg;
  ctrl_t  ctl;
  state_e state_q, state_d;

  pqadc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  // item registers
  logic [CODES_W-1:0]       codes_q;
  logic [ID_W-1:0]          id_q;
  logic [ERR_W-1:0]         err_q;
  logic                     accept;
  op_e                      op_in;

  // running state
  logic signed [DIST_W-1:0] psum_q, sum_q;
  logic [GCW-1:0]           group_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [GSUM_W-1:0] gsum_q, gsum;
  logic [PEN_W-1:0]         pen_q;
  logic                     last_grp;

  // output register
  logic                     ovalid_q, ohit_q;
  logic signed [DIST_W-1:0] odist_q;
  logic [ID_W-1:0]          oid_q;

  assign accept   = in_if.valid && ctl.in_ready;
  assign op_in    = op_e'(in_if.operation);
  assign last_grp = (32'(group_q) == 32'(GROUPS - 1));

  // ---- banked table ----
  logic [MW-1:0]    wr_m;
  logic             wr_any;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] rdata [GROUP_SIZE];

  assign wr_m   = in_if.table_index[TIDX_W-1:CODE_BITS];
  assign wr_any = accept && (op_in == OP_LOAD) &&
                  (32'(wr_m) < 32'(GROUPS * GROUP_SIZE));
  assign waddr  = AW'((32'(wr_m) >> 3) * CENTROIDS +
                      32'(in_if.table_index[CODE_BITS-1:0]));

  for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_bank
    logic [AW-1:0] raddr;
    assign raddr = AW'(32'(group_q) * CENTROIDS + 32'(codes_q[k*CODE_BITS +: CODE_BITS]));
    pqadc_ram #(.WIDTH(VAL_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk_i,
      .we_i   (wr_any && (wr_m[2:0] == 3'(k))),
      .waddr_i(waddr),
      .wdata_i(in_if.table_value),
      .re_i   (ctl.rd_en),
      .raddr_i(raddr),
      .rdata_o(rdata[k])
    );
  end

  always_comb begin
    gsum = '0;
    for (int k = 0; k < GROUP_SIZE; k++) begin
      gsum = gsum + GSUM_W'(signed'(rdata[k]));
    end
  end

  // ---- accumulate and saturate ----
  logic signed [DIST_W:0]   acc;
  logic signed [DIST_W-1:0] acc_sat, start;
  localparam logic signed [DIST_W:0] SAT_HI = (DIST_W+1)'({1'b0, {(DIST_W-1){1'b1}}});
  localparam logic signed [DIST_W:0] SAT_LO = -SAT_HI - 1;

  assign start   = (group_q == '0) ? DIST_W'(cfg.base_distance) : psum_q;
  assign acc     = (DIST_W+1)'(start) + (DIST_W+1)'(gsum_q);
  assign acc_sat = (acc > SAT_HI) ? DIST_W'(SAT_HI) :
                   (acc < SAT_LO) ? DIST_W'(SAT_LO) : DIST_W'(acc);

  // ---- decision ----
  logic              conf_mode, neg, busy, hit;
  logic [ROOT_W-1:0] root;
  logic signed [PEN_W+1:0] diff;
  logic [PEN_W+1:0]        adiff;

  assign conf_mode = (cfg.confidence != '0) && (cfg.confidence <= CONF_MAX);
  assign neg       = sum_q[DIST_W-1];

  pqadc_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i   (ctl.sqrt_start),
    .radicand_i({acc_sat, 16'b0}),
    .busy_o    (busy),
    .root_o    (root)
  );

  assign diff  = (PEN_W+2)'(root) - (PEN_W+2)'(pen_q);
  assign adiff = diff[PEN_W+1] ? (PEN_W+2)'(-diff) : (PEN_W+2)'(diff);

  always_comb begin
    if (conf_mode) begin
      hit = !neg && (adiff <= (PEN_W+2)'(cfg.radius_root));
    end else if (cfg.metric_ip) begin
      hit = sum_q > DIST_W'(cfg.radius);
    end else begin
      hit = sum_q < DIST_W'(cfg.radius);
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && op_in == OP_CODE) state_d = ST_READ;
      ST_READ: state_d = ST_ADD;
      ST_ADD:  state_d = ST_ACC;
      ST_ACC: begin
        if (!last_grp) begin
          state_d = ST_IDLE;
        end else if (conf_mode && !acc_sat[DIST_W-1]) begin
          state_d = ST_SQRT;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SQRT: if (!busy) state_d = ST_FIN;
      ST_FIN:  if (!ovalid_q || out_if.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_READ: ctl.rd_en = 1'b1;
      ST_ACC:  ctl.sqrt_start = last_grp && conf_mode && !acc_sat[DIST_W-1];
      ST_FIN:  ctl.out_load = !ovalid_q || out_if.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      psum_q   <= '0;
      group_q  <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && op_in == OP_BEGIN) begin
        psum_q  <= '0;
        group_q <= '0;
        pos_q   <= '0;
      end
      if (state_q == ST_ACC) begin
        psum_q  <= acc_sat;
        group_q <= last_grp ? '0 : group_q + 1'b1;
      end
      if (ctl.out_load) begin
        pos_q <= pos_q + 1'b1;
      end
      if (ctl.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_in == OP_CODE) begin
      codes_q <= in_if.subcodes;
      id_q    <= in_if.entry_id;
      err_q   <= in_if.recon_error;
    end
    if (state_q == ST_ADD) begin
      gsum_q <= gsum;
      pen_q  <= PEN_W'((PROD_W'(err_q) * PROD_W'(cfg.confidence)) >> 16);
    end
    if (state_q == ST_ACC) begin
      sum_q <= acc_sat;
    end
    if (ctl.out_load) begin
      ohit_q  <= hit;
      odist_q <= sum_q;
      oid_q   <= cfg.pairs_en ? {cfg.list_key, pos_q} : id_q;
    end
  end

  assign in_if.ready      = ctl.in_ready;
  assign out_if.valid     = ovalid_q;
  assign out_if.hit       = ohit_q;
  assign out_if.distance  = odist_q;
  assign out_if.result_id = oid_q;

  // ---- checks ----
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!ovalid_q || out_if.ready))
    else $error("result written over a waiting word");

  a_group_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(group_q) < 32'(GROUPS))
    else $error("group counter out of range");

  a_code_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_in == OP_CODE) |=> (state_q == ST_READ))
    else $error("code group not followed by table read");

  a_sqrt_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (state_q == ST_SQRT))
    else $error("root unit busy outside its state");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_if.ready) |=> ovalid_q)
    else $error("waiting result dropped");

endmodule

@@ rtl/pqadc_ram.sv @@
// ----------------------------------------------------------------------------
// pqadc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pqadc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pqadc_regs.sv @@
// ----------------------------------------------------------------------------
// pqadc_regs
// APB register file holding the filter configuration.
// ----------------------------------------------------------------------------
module pqadc_regs import pqadc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr;

  assign sel    = reg_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_METRIC: cfg_d.metric_ip     = pwdata[0];
        REG_CONF:   cfg_d.confidence    = pwdata[CONF_W-1:0];
        REG_BASE:   cfg_d.base_distance = pwdata;
        REG_RADIUS: cfg_d.radius        = pwdata;
        REG_RROOT:  cfg_d.radius_root   = pwdata;
        REG_KEY:    cfg_d.list_key      = pwdata[KEY_W-1:0];
        REG_PAIRS:  cfg_d.pairs_en      = pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_METRIC: prdata = {31'b0, cfg_q.metric_ip};
      REG_CONF:   prdata = {15'b0, cfg_q.confidence};
      REG_BASE:   prdata = cfg_q.base_distance;
      REG_RADIUS: prdata = cfg_q.radius;
      REG_RROOT:  prdata = cfg_q.radius_root;
      REG_KEY:    prdata = {1'b0, cfg_q.list_key};
      REG_PAIRS:  prdata = {31'b0, cfg_q.pairs_en};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/pqadc_sqrt.sv @@
// ----------------------------------------------------------------------------
// pqadc_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pqadc_sqrt import pqadc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned CW = $clog2(ROOT_W + 1);

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic [RAD_W-1:0]  x_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_sh, trial;

  assign rem_sh = {rem_q[REM_W-3:0], x_q[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(ROOT_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q <= {x_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule
